// ===== src/raid5sw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5sw_pkg
// Shared widths and register codes of the RAID-5 stripe writer.
// ----------------------------------------------------------------------------
package raid5sw_pkg;

  localparam int DATA_W     = 8;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_CFG_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'b1;

endpackage

// ===== src/raid5sw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5sw interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface raid5sw_in_if;
  import raid5sw_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface raid5sw_out_if #(
  parameter int DISK_W = 2,
  parameter int OFF_W  = 2
);
  import raid5sw_pkg::*;
  logic              valid;
  logic              ready;
  logic [DISK_W-1:0] disk_index;
  logic [POS_W-1:0]  stripe_position;
  logic [OFF_W-1:0]  byte_offset;
  logic [DATA_W-1:0] out_byte;
  logic              is_parity;
  logic              run_end;
  modport source (output valid, output disk_index, output stripe_position,
                  output byte_offset, output out_byte, output is_parity,
                  output run_end, input ready);
  modport sink   (input valid, input disk_index, input stripe_position,
                  input byte_offset, input out_byte, input is_parity,
                  input run_end, output ready);
endinterface

interface raid5sw_cfg_if;
  import raid5sw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/raid5sw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5sw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module raid5sw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/raid5_stripe_writer_core.sv =====
`timescale 1ns / 1ps
// A data byte appears on the output register in the cycle after it is taken.
// One data byte is taken per cycle while the output slot can load; a stripe close
//   emits any zero pad bytes and then the parity block, read back from the parity RAM.
// Reset: after rst_ni releases, a clearing pass zeroes the parity RAM entry by entry,
//   during which no item is taken; config writes are always taken.
// ----------------------------------------------------------------------------
// raid5_stripe_writer_core
// Lays a byte stream out in RAID-5 stripes with rotating parity; the per-offset
// parity accumulator lives in a RAM updated by read-modify-write.
// ----------------------------------------------------------------------------
module raid5_stripe_writer_core #(
  parameter int BLOCK_BYTES = 4,
  parameter int MAX_DISKS   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  raid5sw_in_if.sink           in_i,
  raid5sw_out_if.source        out_o,
  raid5sw_cfg_if.sink          cfg_i
);
  import raid5sw_pkg::*;

  localparam int OW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int DW = $clog2(MAX_DISKS);
  localparam int NW = $clog2(MAX_DISKS + 1);
  localparam int ND_RESET = (MAX_DISKS < 4) ? MAX_DISKS : 4;
  localparam logic [OW-1:0] BB_LAST = OW'(BLOCK_BYTES - 1);
  localparam logic [3:0]    MAX4    = 4'(MAX_DISKS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_DATA  = 2'd1;
  localparam logic [1:0] S_PAD   = 2'd2;
  localparam logic [1:0] S_PAR   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [NW-1:0]    nd_q;
  logic [POS_W-1:0] start_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [DW-1:0]    smc_q, smc_d;
  logic [DW-1:0]    dbc_q, dbc_d;
  logic [OW-1:0]    off_q, off_d;
  logic [OW-1:0]    idx_q, idx_d;
  logic             open_q, open_d;
  logic             last_q, last_d;

  logic              ov_q;
  logic [DW-1:0]     o_disk_q, o_disk_d;
  logic [POS_W-1:0]  o_pos_q, o_pos_d;
  logic [OW-1:0]     o_off_q, o_off_d;
  logic [DATA_W-1:0] o_byte_q, o_byte_d;
  logic              o_par_q, o_par_d;
  logic              o_end_q, o_end_d;
  logic              load;

  logic              we;
  logic [OW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, ram_rdata, rd;
  logic              fwd_q;
  logic [DATA_W-1:0] fwd_data_q;

  logic              can_load, in_acc;
  logic [DW-1:0]     smc_e, pidx, dbc_n;
  logic [POS_W-1:0]  pos_e;
  logic [NW-1:0]     nd_m1, pidx_w;
  logic              full;
  logic [3:0]        cfg_v;

  function automatic logic [DW-1:0] data_disk(logic [DW-1:0] blk, logic [DW-1:0] pi);
    return (blk < pi) ? blk : blk + DW'(1);
  endfunction

  raid5sw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BLOCK_BYTES),
    .AW    (OW)
  ) u_parity_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign rd       = fwd_q ? fwd_data_q : ram_rdata;
  assign can_load = !ov_q || out_o.ready;
  assign smc_e    = open_q ? smc_q : '0;
  assign pos_e    = open_q ? pos_q : start_q;
  assign nd_m1    = nd_q - NW'(1);
  assign pidx_w   = nd_m1 - NW'(smc_e);
  assign pidx     = pidx_w[DW-1:0];
  assign in_i.ready = (state_q == S_DATA) && can_load;
  assign in_acc   = in_i.valid && in_i.ready;

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    smc_d    = smc_q;
    dbc_d    = dbc_q;
    off_d    = off_q;
    idx_d    = idx_q;
    open_d   = open_q;
    last_d   = last_q;
    load     = 1'b0;
    o_disk_d = o_disk_q;
    o_pos_d  = o_pos_q;
    o_off_d  = o_off_q;
    o_byte_d = o_byte_q;
    o_par_d  = o_par_q;
    o_end_d  = o_end_q;
    we       = 1'b0;
    waddr    = off_q;
    wdata    = '0;
    dbc_n    = dbc_q;
    full     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = idx_q;
        if (idx_q == BB_LAST) begin
          idx_d   = '0;
          state_d = S_DATA;
        end else begin
          idx_d = idx_q + OW'(1);
        end
      end
      S_DATA: begin
        if (in_acc) begin
          load     = 1'b1;
          o_disk_d = data_disk(dbc_q, pidx);
          o_pos_d  = pos_e;
          o_off_d  = off_q;
          o_byte_d = in_i.data_byte;
          o_par_d  = 1'b0;
          open_d   = 1'b1;
          smc_d    = smc_e;
          pos_d    = pos_e;
          last_d   = in_i.last_byte;
          we       = 1'b1;
          wdata    = rd ^ in_i.data_byte;
          if (off_q == BB_LAST) begin
            off_d = '0;
            dbc_n = dbc_q + DW'(1);
          end else begin
            off_d = off_q + OW'(1);
          end
          dbc_d = dbc_n;
          full  = NW'(dbc_n) >= nd_m1;
          if (full || in_i.last_byte) begin
            o_end_d = 1'b0;
            idx_d   = '0;
            state_d = full ? S_PAR : S_PAD;
          end else begin
            o_end_d = 1'b1;
          end
        end
      end
      S_PAD: begin
        if (can_load) begin
          load     = 1'b1;
          o_disk_d = data_disk(dbc_q, pidx);
          o_pos_d  = pos_q;
          o_off_d  = off_q;
          o_byte_d = '0;
          o_par_d  = 1'b0;
          o_end_d  = 1'b0;
          if (off_q == BB_LAST) begin
            off_d = '0;
            dbc_n = dbc_q + DW'(1);
          end else begin
            off_d = off_q + OW'(1);
          end
          dbc_d = dbc_n;
          full  = NW'(dbc_n) >= nd_m1;
          if (full) begin
            idx_d   = '0;
            state_d = S_PAR;
          end
        end
      end
      S_PAR: begin
        if (can_load) begin
          load     = 1'b1;
          o_disk_d = pidx;
          o_pos_d  = pos_q;
          o_off_d  = idx_q;
          o_byte_d = rd;
          o_par_d  = 1'b1;
          o_end_d  = (idx_q == BB_LAST);
          we       = 1'b1;
          waddr    = idx_q;
          if (idx_q == BB_LAST) begin
            idx_d   = '0;
            off_d   = '0;
            dbc_d   = '0;
            pos_d   = pos_q + POS_W'(1);
            open_d  = !last_q;
            state_d = S_DATA;
            if (last_q || (NW'(smc_q) + NW'(1) == nd_q)) begin
              smc_d = '0;
            end else begin
              smc_d = smc_q + DW'(1);
            end
          end else begin
            idx_d = idx_q + OW'(1);
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign raddr = (state_d == S_PAR) ? idx_d : off_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pos_q   <= '0;
      smc_q   <= '0;
      dbc_q   <= '0;
      off_q   <= '0;
      idx_q   <= '0;
      open_q  <= 1'b0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      smc_q   <= smc_d;
      dbc_q   <= dbc_d;
      off_q   <= off_d;
      idx_q   <= idx_d;
      open_q  <= open_d;
      last_q  <= last_d;
      fwd_q   <= we && (waddr == raddr);
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
    if (load) begin
      o_disk_q <= o_disk_d;
      o_pos_q  <= o_pos_d;
      o_off_q  <= o_off_d;
      o_byte_q <= o_byte_d;
      o_par_q  <= o_par_d;
      o_end_q  <= o_end_d;
    end
  end

  // config registers
  assign cfg_i.ready = 1'b1;
  assign cfg_v       = {1'b0, cfg_i.data[CNT_CFG_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q    <= NW'(ND_RESET);
      start_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_DISK_COUNT: begin
          if (!open_q) begin
            if (cfg_v < 4'd2) begin
              nd_q <= NW'(2);
            end else if (cfg_v > MAX4) begin
              nd_q <= NW'(MAX_DISKS);
            end else begin
              nd_q <= cfg_v[NW-1:0];
            end
          end
        end
        REG_START_POSITION: begin
          start_q <= cfg_i.data[POS_W-1:0];
        end
        default: begin
          start_q <= start_q;
        end
      endcase
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.disk_index      = o_disk_q;
  assign out_o.stripe_position = o_pos_q;
  assign out_o.byte_offset     = o_off_q;
  assign out_o.out_byte        = o_byte_q;
  assign out_o.is_parity       = o_par_q;
  assign out_o.run_end         = o_end_q;

  a_acc_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!ov_q || out_o.ready))
    else $error("item taken while result slot is blocked");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!ov_q && !open_q))
    else $error("activity during parity clearing pass");

  a_rotation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (NW'(smc_q) < nd_q))
    else $error("parity rotation count out of range");

  a_parity_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && o_par_d && (o_off_d == BB_LAST)) |=> (ov_q && o_end_q && state_q == S_DATA))
    else $error("parity block did not close the stripe");

  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAR && state_d == S_PAR && can_load) |=> (fwd_q == 1'b0 || idx_q == '0))
    else $error("unexpected parity RAM forward during parity readout");

endmodule
